FILE: hdl/assert_macros.svh
// Assertion macros shared by the decimating FIR blocks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define FDB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is followed in the next cycle by another
`define FDB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/fdb_pkg.sv
// Shared constants, types and the tap table of the decimating FIR filter
package fdb_pkg;

	localparam int TAP_COUNT    = 127;
	localparam int SAMPLE_WIDTH = 16;
	localparam int COEF_WIDTH   = 18;
	localparam int COEF_FRAC    = COEF_WIDTH - 1;

	// Job queue between the sample front end and the MAC engine (power of two)
	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

	// Ring holds the taps plus the samples the front end may run ahead
	localparam int RING_AW      = $clog2(TAP_COUNT + 2 * QUEUE_DEPTH + 2);
	localparam int RING_DEPTH   = 2 ** RING_AW;

	localparam int IDX_WIDTH    = $clog2(TAP_COUNT);
	localparam int FILL_WIDTH   = $clog2(TAP_COUNT + 1);
	localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_WIDTH    = PROD_WIDTH + $clog2(TAP_COUNT);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEF_WIDTH-1:0]   coef_t;
	typedef logic signed [PROD_WIDTH-1:0]   product_t;
	typedef logic signed [ACC_WIDTH-1:0]    acc_t;
	typedef logic [RING_AW-1:0]             ring_addr_t;
	typedef logic [IDX_WIDTH-1:0]           tap_idx_t;
	typedef logic [FILL_WIDTH-1:0]          fill_t;
	typedef coef_t                          coef_table_t [TAP_COUNT];

	typedef logic [63:0]        u64_t;
	typedef logic signed [63:0] s64_t;

	// Ring write port driven by the front end
	typedef struct packed {
		logic       en;
		ring_addr_t addr;
		sample_t    data;
	} ring_wr_t;

	// One filter output to compute: ring slot of the newest sample
	typedef struct packed {
		ring_addr_t newest;
	} mac_job_t;

	typedef struct packed {
		logic     valid;
		mac_job_t job;
	} job_push_t;

	typedef enum logic [1:0] {
		MAC_IDLE,
		MAC_RUN,
		MAC_DRAIN,
		MAC_DONE
	} mac_state_t;

	// Tap design constants, Q30 fixed point
	localparam u64_t CUTOFF_NUM      = 64'd9;
	localparam u64_t CUTOFF_DEN      = 64'd40;
	localparam u64_t Q30_ONE         = 64'd1073741824;
	localparam u64_t PI_HALF_Q30     = 64'd1686629713;
	localparam s64_t TWO_OVER_PI_Q30 = 64'sd683565276;
	localparam s64_t WIN_A0_Q30      = 64'sd450971566;
	localparam s64_t WIN_A2_Q30      = 64'sd85899346;
	localparam int unsigned SINE_DIVS [7] = '{210, 156, 110, 72, 42, 20, 6};

	// Shift-subtract division, evaluated only while building the tap table
	function automatic u64_t udiv64(input u64_t num, input u64_t den, input logic want_rem);
		u64_t q;
		u64_t r;
		int   b;
		q = '0;
		r = '0;
		for (b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r    = r - den;
				q[b] = 1'b1;
			end
		end
		return want_rem ? r : q;
	endfunction

	// Q30 product, truncated toward zero
	function automatic s64_t mul_q30(input s64_t a, input s64_t b);
		logic neg;
		u64_t ua;
		u64_t ub;
		u64_t p;
		neg = a[63] ^ b[63];
		ua  = a[63] ? u64_t'(-a) : u64_t'(a);
		ub  = b[63] ? u64_t'(-b) : u64_t'(b);
		p   = (ua * ub) >> 30;
		return neg ? -s64_t'(p) : s64_t'(p);
	endfunction

	// Angle pi*num/den as a 32-bit fraction of a full turn, rounded
	function automatic logic [31:0] turn_phase(input u64_t num, input u64_t den);
		u64_t span;
		u64_t m;
		u64_t t;
		span = den << 1;
		m    = udiv64(num, span, 1'b1);
		t    = udiv64((m << 32) + den, span, 1'b0);
		return t[31:0];
	endfunction

	// Sine over the first quadrant by a truncating Taylor series
	function automatic u64_t quarter_sine(input u64_t q);
		u64_t x;
		u64_t x2;
		u64_t r;
		int   k;
		x  = (q * PI_HALF_Q30) >> 30;
		x2 = (x * x) >> 30;
		r  = Q30_ONE;
		for (k = 0; k < 7; k++) begin
			r = Q30_ONE - udiv64((x2 * r) >> 30, u64_t'(SINE_DIVS[k]), 1'b0);
		end
		return (x * r) >> 30;
	endfunction

	function automatic s64_t sin_q30(input logic [31:0] phase);
		u64_t q;
		s64_t s;
		q = {34'd0, phase[29:0]};
		s = phase[30] ? s64_t'(quarter_sine(Q30_ONE - q)) : s64_t'(quarter_sine(q));
		return phase[31] ? -s : s;
	endfunction

	function automatic s64_t cos_q30(input logic [31:0] phase);
		logic [31:0] shifted;
		shifted = phase + 32'h4000_0000;
		return sin_q30(shifted);
	endfunction

	// Signed division truncated toward zero, divisor positive
	function automatic s64_t sdiv_trunc(input s64_t num, input s64_t den);
		u64_t mag;
		s64_t q;
		mag = num[63] ? u64_t'(-num) : u64_t'(num);
		q   = s64_t'(udiv64(mag, u64_t'(den), 1'b0));
		return num[63] ? -q : q;
	endfunction

	// Blackman-windowed sinc taps, normalized to unit sum and rounded
	function automatic coef_table_t build_taps();
		coef_table_t tbl;
		s64_t        vals [TAP_COUNT];
		s64_t        sum;
		s64_t        d;
		s64_t        ad;
		s64_t        sinc;
		s64_t        win;
		s64_t        s;
		s64_t        t;
		s64_t        cmax;
		s64_t        cmin;
		u64_t        mag;
		u64_t        span;
		int          i;
		sum  = '0;
		cmax = (s64_t'(1) <<< COEF_FRAC) - 1;
		cmin = -(s64_t'(1) <<< COEF_FRAC);
		span = u64_t'(TAP_COUNT - 1);
		for (i = 0; i < TAP_COUNT; i++) begin
			d  = s64_t'(2 * i) - s64_t'(TAP_COUNT - 1);
			ad = d[63] ? -d : d;
			if (ad == 0) begin
				sinc = s64_t'(udiv64((CUTOFF_NUM << 1) << 30, CUTOFF_DEN, 1'b0));
			end else begin
				s    = sin_q30(turn_phase(CUTOFF_NUM * u64_t'(ad), CUTOFF_DEN));
				sinc = sdiv_trunc(mul_q30(s, TWO_OVER_PI_Q30), ad);
			end
			t = cos_q30(turn_phase(u64_t'(2 * i), span));
			win = WIN_A0_Q30
				- (t[63] ? -s64_t'(u64_t'(-t) >> 1) : s64_t'(u64_t'(t) >> 1))
				+ mul_q30(WIN_A2_Q30, cos_q30(turn_phase(u64_t'(4 * i), span)));
			vals[i] = mul_q30(sinc, win);
			sum     = sum + vals[i];
		end
		if (sum <= 0) begin
			sum = s64_t'(Q30_ONE);
		end
		for (i = 0; i < TAP_COUNT; i++) begin
			mag = vals[i][63] ? u64_t'(-vals[i]) : u64_t'(vals[i]);
			t   = s64_t'(udiv64((mag << COEF_FRAC) + (u64_t'(sum) >> 1), u64_t'(sum), 1'b0));
			if (vals[i][63]) begin
				t = -t;
			end
			if (t > cmax) begin
				t = cmax;
			end
			if (t < cmin) begin
				t = cmin;
			end
			tbl[i] = t[COEF_WIDTH-1:0];
		end
		return tbl;
	endfunction

	localparam coef_table_t COEF_TABLE = build_taps();

endpackage

FILE: hdl/fdb_ifs.sv
// Valid/ready stream interfaces for the filter input and output samples
interface fdb_in_if;
	import fdb_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface fdb_out_if;
	import fdb_pkg::*;
	logic    valid;
	logic    ready;
	sample_t filtered_sample;
	modport source (output valid, output filtered_sample, input ready);
	modport sink (input valid, input filtered_sample, output ready);
endinterface

FILE: hdl/fdb_ram.sv
// Generic simple dual-port RAM with registered read
module fdb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: hdl/fdb_front.sv
// Front end: accepts samples, writes the ring and issues output jobs
module fdb_front (
	input  logic              clk,
	input  logic              arst_n,
	fdb_in_if.sink            sample_ch,
	output fdb_pkg::ring_wr_t  ring_wr,
	output fdb_pkg::job_push_t job_push,
	input  logic              queue_full
);
	import fdb_pkg::*;

	ring_addr_t wpos_q;
	fill_t      fill_q;
	fill_t      fill_next;
	logic       phase_q;
	logic       due;
	logic       accept;

	// Saturate the fill count; an output is due on every second sample once full
	assign fill_next = (fill_q == FILL_WIDTH'(TAP_COUNT)) ? fill_q : fill_q + 1'b1;
	assign due       = (fill_next == FILL_WIDTH'(TAP_COUNT)) && phase_q;

	// Hold off a due sample while the job queue is full
	assign sample_ch.ready = !(due && queue_full);
	assign accept          = sample_ch.valid && sample_ch.ready;

	assign ring_wr.en   = accept;
	assign ring_wr.addr = wpos_q;
	assign ring_wr.data = sample_ch.sample_in;

	assign job_push.valid      = accept && due;
	assign job_push.job.newest = wpos_q;

	// Advance ring position, fill count and phase per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q  <= '0;
			fill_q  <= '0;
			phase_q <= 1'b0;
		end else if (accept) begin
			wpos_q  <= wpos_q + 1'b1;
			fill_q  <= fill_next;
			phase_q <= ~phase_q;
		end
	end
endmodule

FILE: hdl/fdb_queue.sv
// Short job queue between the front end and the MAC engine
module fdb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  fdb_pkg::job_push_t job_push,
	output logic              full,
	input  logic              pop,
	output fdb_pkg::mac_job_t  head,
	output logic              empty
);
	import fdb_pkg::*;

	`include "assert_macros.svh"

	mac_job_t                slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]     wr_ptr_q;
	logic [QUEUE_AW-1:0]     rd_ptr_q;
	logic [QUEUE_CW-1:0]     count_q;

	assign full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (job_push.valid) begin
			slots_q[wr_ptr_q] <= job_push.job;
		end
	end

	// Advance pointers and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (job_push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({job_push.valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`FDB_ASSERT(a_no_push_when_full, !(job_push.valid && full), "job pushed into a full queue")
	`FDB_ASSERT(a_no_pop_when_empty, !(pop && empty), "job popped from an empty queue")
	`FDB_ASSERT(a_count_in_range, count_q <= QUEUE_CW'(QUEUE_DEPTH), "queue count out of range")
endmodule

FILE: hdl/fdb_mac.sv
// Back end: multiply-accumulate over the ring, round, saturate and output
module fdb_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_empty,
	input  fdb_pkg::mac_job_t   job_head,
	output logic               job_pop,
	output logic               ring_rd_en,
	output fdb_pkg::ring_addr_t ring_rd_addr,
	input  fdb_pkg::sample_t    ring_rd_data,
	fdb_out_if.source          result_ch
);
	import fdb_pkg::*;

	`include "assert_macros.svh"

	localparam int SCALED_WIDTH = ACC_WIDTH + 1 - COEF_FRAC;

	mac_state_t state_q;
	mac_state_t state_d;
	logic       start;
	logic       issue;
	logic       load;

	ring_addr_t addr_q;
	tap_idx_t   k_q;
	logic       valid_s1;
	tap_idx_t   idx_s1;
	logic       valid_s2;
	product_t   product_s2;
	acc_t       acc_q;
	logic       out_valid_q;
	sample_t    out_data_q;

	logic signed [ACC_WIDTH:0]      rounded;
	logic signed [SCALED_WIDTH-1:0] scaled;
	logic                           fits;
	sample_t                        saturated;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MAC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control
	always_comb begin
		state_d = state_q;
		start   = 1'b0;
		issue   = 1'b0;
		load    = 1'b0;
		case (state_q)
			MAC_IDLE: begin
				if (!job_empty) begin
					start   = 1'b1;
					state_d = MAC_RUN;
				end
			end
			MAC_RUN: begin
				issue = 1'b1;
				if (k_q == IDX_WIDTH'(TAP_COUNT - 1)) begin
					state_d = MAC_DRAIN;
				end
			end
			MAC_DRAIN: begin
				if (!valid_s1 && !valid_s2) begin
					state_d = MAC_DONE;
				end
			end
			MAC_DONE: begin
				if (!out_valid_q || result_ch.ready) begin
					load    = 1'b1;
					state_d = MAC_IDLE;
				end
			end
			default: begin
				state_d = MAC_IDLE;
			end
		endcase
	end

	assign job_pop      = start;
	assign ring_rd_en   = issue;
	assign ring_rd_addr = addr_q;

	// Walk the history newest first, one tap per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			addr_q <= job_head.newest;
			k_q    <= '0;
		end else if (issue) begin
			addr_q <= addr_q - 1'b1;
			k_q    <= k_q + 1'b1;
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	// Multiply ring sample by its tap, then accumulate
	always_ff @(posedge clk) begin
		idx_s1     <= k_q;
		product_s2 <= ring_rd_data * COEF_TABLE[idx_s1];
		if (start) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_WIDTH'(product_s2);
		end
	end

	// Round to nearest, drop fraction bits, saturate to the sample range
	assign rounded = $signed({acc_q[ACC_WIDTH-1], acc_q})
		+ $signed((ACC_WIDTH + 1)'(1) <<< (COEF_FRAC - 1));
	assign scaled  = $signed(rounded[ACC_WIDTH:COEF_FRAC]);
	assign fits    = (&scaled[SCALED_WIDTH-1:SAMPLE_WIDTH-1])
		|| !(|scaled[SCALED_WIDTH-1:SAMPLE_WIDTH-1]);
	assign saturated = fits ? scaled[SAMPLE_WIDTH-1:0]
		: {scaled[SCALED_WIDTH-1], {(SAMPLE_WIDTH-1){~scaled[SCALED_WIDTH-1]}}};

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= saturated;
		end
	end

	assign result_ch.valid           = out_valid_q;
	assign result_ch.filtered_sample = out_data_q;

	`FDB_ASSERT(a_pipe_empty_at_done, (state_q != MAC_DONE) || (!valid_s1 && !valid_s2),
		"result loaded with products still in flight")
	`FDB_ASSERT(a_acc_only_in_job, !valid_s2 || state_q == MAC_RUN || state_q == MAC_DRAIN,
		"product accumulated outside a job")
	`FDB_ASSERT_NEXT(a_load_fills_output, load, out_valid_q, "loaded result not presented")
endmodule

FILE: hdl/fir_decimate_by_two.sv
// Top level of the decimate-by-two lowpass FIR filter
// The single MAC walks all 127 taps for each result, one result at a time;
//   samples enter one per cycle in bursts while the job queue has room.
// Reset: asynchronous, clears ring position, fill count, phase, queue and output;
//   no clearing pass, the taps are a constant table and the ring fills before use.
module fir_decimate_by_two (
	input  logic       clk,
	input  logic       arst_n,
	fdb_in_if.sink     sample_ch,
	fdb_out_if.source  result_ch
);
	import fdb_pkg::*;

	ring_wr_t   ring_wr;
	job_push_t  job_push;
	logic       queue_full;
	logic       queue_empty;
	logic       job_pop;
	mac_job_t   job_head;
	logic       ring_rd_en;
	ring_addr_t ring_rd_addr;
	sample_t    ring_rd_data;

	fdb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_ch  (sample_ch),
		.ring_wr    (ring_wr),
		.job_push   (job_push),
		.queue_full (queue_full)
	);

	fdb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_push (job_push),
		.full     (queue_full),
		.pop      (job_pop),
		.head     (job_head),
		.empty    (queue_empty)
	);

	fdb_ram #(
		.WIDTH (SAMPLE_WIDTH),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ring_wr.en),
		.waddr (ring_wr.addr),
		.wdata (ring_wr.data),
		.re    (ring_rd_en),
		.raddr (ring_rd_addr),
		.rdata (ring_rd_data)
	);

	fdb_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_empty    (queue_empty),
		.job_head     (job_head),
		.job_pop      (job_pop),
		.ring_rd_en   (ring_rd_en),
		.ring_rd_addr (ring_rd_addr),
		.ring_rd_data (ring_rd_data),
		.result_ch    (result_ch)
	);
endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the decimate-by-two lowpass FIR filter
`timescale 1ns / 100ps

module tb_top;
	import fdb_pkg::*;

	typedef bit [63:0] uword_t;
	typedef longint    sword_t;
	typedef logic signed [COEF_WIDTH-1:0] tap_t;

	// Tap design constants, Q30 fixed point
	localparam uword_t Q30_UNIT       = 64'd1073741824;
	localparam uword_t HALF_PI_Q30    = 64'd1686629713;
	localparam sword_t INV_HALF_PI    = 64'sd683565276;
	localparam sword_t BLACKMAN_A0    = 64'sd450971566;
	localparam sword_t BLACKMAN_A2    = 64'sd85899346;
	localparam int     CUT_NUM        = 9;
	localparam int     CUT_DEN        = 40;
	localparam int     COEF_FRAC_BITS = COEF_WIDTH - 1;
	localparam sword_t OUT_MAX        = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
	localparam sword_t OUT_MIN        = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

	// Run shape
	localparam int TARGET_ITEMS = 1774;
	localparam int DRAIN_AFTER  = 900;
	localparam int TAIL_ITEMS   = 250;
	localparam int HOLD_AFTER   = 25;
	localparam int HOLD_CYCLES  = 2500;
	localparam int SETTLE_CYCLES = 200;
	localparam int LIMIT_NS     = 20000000;

	typedef struct {
		sample_t value;
		bit      wait_drain;
	} stim_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	fdb_in_if  sample_ch ();
	fdb_out_if result_ch ();

	fir_decimate_by_two u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	// Predictor state
	tap_t    tap_rom [TAP_COUNT];
	sample_t hist_ring [TAP_COUNT];
	int      hist_wr;
	int      hist_fill;
	bit      hist_phase;

	sample_t    expected_filtered [$];
	stim_item_t stim_q [$];
	stim_item_t next_item;
	int         queued_items;
	bit         drain_next;
	bit         drain_marked;

	bit outputs_drained = 1'b1;
	bit tail_mode;
	int results_seen;
	int fail_count;
	int hold_left;
	bit hold_done;

	int tx_idle_left;
	int tx_rate;
	int tx_cycle;
	int rx_idle_left;
	int rx_rate;
	int rx_cycle;
	sample_t want;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Q30 product truncated toward zero
	function automatic sword_t q30_mul(sword_t a, sword_t b);
		bit     neg;
		uword_t ua;
		uword_t ub;
		uword_t p;
		neg = (a < 0) != (b < 0);
		ua  = (a < 0) ? uword_t'(-a) : uword_t'(a);
		ub  = (b < 0) ? uword_t'(-b) : uword_t'(b);
		p   = (ua * ub) >> 30;
		return neg ? -$signed(p) : $signed(p);
	endfunction

	// Angle pi*num/den as a rounded 32-bit turn fraction
	function automatic bit [31:0] turn_frac(uword_t num, uword_t den);
		uword_t span;
		uword_t m;
		span = den * 2;
		m    = num % span;
		return 32'(((m << 32) + den) / span);
	endfunction

	// First-quadrant sine by truncating Horner steps
	function automatic uword_t sine_quarter(uword_t q);
		int unsigned divs [7];
		uword_t x;
		uword_t x2;
		uword_t r;
		divs = '{210, 156, 110, 72, 42, 20, 6};
		x  = (q * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		r  = Q30_UNIT;
		for (int k = 0; k < 7; k++) begin
			r = Q30_UNIT - ((x2 * r) >> 30) / uword_t'(divs[k]);
		end
		return (x * r) >> 30;
	endfunction

	function automatic sword_t sine_turn(bit [31:0] ph);
		uword_t q;
		sword_t s;
		q = {34'd0, ph[29:0]};
		s = ph[30] ? $signed(sine_quarter(Q30_UNIT - q)) : $signed(sine_quarter(q));
		return ph[31] ? -s : s;
	endfunction

	function automatic sword_t cosine_turn(bit [31:0] ph);
		return sine_turn(ph + 32'h4000_0000);
	endfunction

	// Build the windowed sinc taps and normalize them to unit sum
	function automatic void compute_taps();
		sword_t vals [TAP_COUNT];
		sword_t total;
		sword_t sinc;
		sword_t win;
		sword_t t;
		uword_t mag;
		int     d;
		int     ad;
		total = 0;
		for (int i = 0; i < TAP_COUNT; i++) begin
			d  = 2 * i - (TAP_COUNT - 1);
			ad = (d < 0) ? -d : d;
			if (ad == 0) begin
				sinc = $signed((uword_t'(2 * CUT_NUM) << 30) / uword_t'(CUT_DEN));
			end else begin
				sinc = q30_mul(sine_turn(turn_frac(CUT_NUM * ad, CUT_DEN)), INV_HALF_PI)
					/ sword_t'(ad);
			end
			win = BLACKMAN_A0
				- cosine_turn(turn_frac(2 * i, TAP_COUNT - 1)) / 2
				+ q30_mul(BLACKMAN_A2, cosine_turn(turn_frac(4 * i, TAP_COUNT - 1)));
			vals[i] = q30_mul(sinc, win);
			total   = total + vals[i];
		end
		if (total <= 0) begin
			total = $signed(Q30_UNIT);
		end
		for (int i = 0; i < TAP_COUNT; i++) begin
			mag = (vals[i] < 0) ? uword_t'(-vals[i]) : uword_t'(vals[i]);
			t   = $signed(((mag << COEF_FRAC_BITS) + uword_t'(total) / 2) / uword_t'(total));
			if (vals[i] < 0) begin
				t = -t;
			end
			if (t > (64'sd1 <<< COEF_FRAC_BITS) - 1) begin
				t = (64'sd1 <<< COEF_FRAC_BITS) - 1;
			end
			if (t < -(64'sd1 <<< COEF_FRAC_BITS)) begin
				t = -(64'sd1 <<< COEF_FRAC_BITS);
			end
			tap_rom[i] = t[COEF_WIDTH-1:0];
		end
	endfunction

	// Store one accepted sample and queue the filtered output it completes
	function automatic void predict_sample(sample_t x);
		sword_t acc;
		sword_t rounded;
		int     pos;
		hist_ring[hist_wr] = x;
		hist_wr = (hist_wr + 1) % TAP_COUNT;
		if (hist_fill < TAP_COUNT) begin
			hist_fill++;
		end
		hist_phase = ~hist_phase;
		if (hist_fill == TAP_COUNT && !hist_phase) begin
			acc = 0;
			pos = (hist_wr + TAP_COUNT - 1) % TAP_COUNT;
			for (int k = 0; k < TAP_COUNT; k++) begin
				acc = acc + sword_t'(tap_rom[k]) * sword_t'(hist_ring[pos]);
				pos = (pos + TAP_COUNT - 1) % TAP_COUNT;
			end
			rounded = (acc + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
			if (rounded > OUT_MAX) begin
				rounded = OUT_MAX;
			end
			if (rounded < OUT_MIN) begin
				rounded = OUT_MIN;
			end
			expected_filtered.push_back(sample_t'(rounded));
		end
	endfunction

	function automatic void push_sample(sample_t value);
		stim_item_t it;
		it.value      = value;
		it.wait_drain = drain_next;
		drain_next    = 1'b0;
		stim_q.push_back(it);
		queued_items++;
	endfunction

	// Line up full-scale samples with the tap signs so the output saturates
	function automatic void push_tap_pattern(bit negate);
		if ((queued_items + TAP_COUNT) % 2 != 0) begin
			push_sample(sample_t'($urandom_range(0, 65535)));
		end
		for (int k = TAP_COUNT - 1; k >= 0; k--) begin
			push_sample(((tap_rom[k] >= 0) ^ negate) ? sample_t'(OUT_MAX) : sample_t'(OUT_MIN));
		end
	endfunction

	// Hold reset, then release it away from the clock edge
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Build the tap table and the whole stimulus list
	initial begin
		int kind;
		int len;
		sample_t level;
		compute_taps();
		for (int i = 0; i < TAP_COUNT; i++) begin
			hist_ring[i] = '0;
		end
		// Directed: extremes, checker patterns and a walking one
		push_sample(sample_t'(OUT_MAX));
		push_sample(sample_t'(OUT_MIN));
		push_sample('0);
		push_sample(-16'sd1);
		push_sample(16'sd1);
		push_sample(sample_t'(16'h5555));
		push_sample(sample_t'(16'haaaa));
		for (int i = 0; i < SAMPLE_WIDTH; i++) begin
			push_sample(sample_t'(1 << i));
		end
		// Random segments of varied character
		while (queued_items < TARGET_ITEMS) begin
			if (!drain_marked && queued_items >= DRAIN_AFTER) begin
				drain_next   = 1'b1;
				drain_marked = 1'b1;
			end
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3: begin
					len = $urandom_range(20, 120);
					repeat (len) push_sample(sample_t'($urandom_range(0, 65535)));
				end
				4: begin
					len = $urandom_range(20, 120);
					repeat (len) push_sample(sample_t'(int'($urandom_range(0, 64)) - 32));
				end
				5: begin
					case ($urandom_range(0, 2))
						0: level = sample_t'(OUT_MAX);
						1: level = sample_t'(OUT_MIN);
						default: level = sample_t'($urandom_range(0, 65535));
					endcase
					len = $urandom_range(140, 200);
					repeat (len) push_sample(level);
				end
				6: begin
					push_tap_pattern(1'b0);
				end
				7: begin
					push_tap_pattern(1'b1);
				end
				8: begin
					len = $urandom_range(20, 80);
					repeat (len) push_sample($urandom_range(0, 1) ? sample_t'(OUT_MAX)
						: sample_t'(OUT_MIN));
				end
				default: begin
					len = $urandom_range(50, 150);
					for (int i = 0; i < len; i++) begin
						push_sample(i[0] ? sample_t'(OUT_MAX) : sample_t'(OUT_MIN));
					end
				end
			endcase
		end
	end

	// Snapshot the expectation store between edges
	always @(negedge clk) begin
		outputs_drained <= (expected_filtered.size() == 0);
	end

	// Driver: offer samples with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid     <= 1'b0;
			sample_ch.sample_in <= '0;
			tail_mode           <= 1'b0;
		end else begin
			// Predict the transaction that completed at this edge
			if (sample_ch.valid && sample_ch.ready) begin
				predict_sample(sample_ch.sample_in);
			end
			tx_cycle++;
			if (tx_cycle % 400 == 0) begin
				tx_rate = $urandom_range(0, 3);
			end
			if (tail_mode) begin
				tx_idle_left = 0;
			end
			tail_mode <= (stim_q.size() < TAIL_ITEMS);
			// Advance to the next sample once the current one is gone
			if (!sample_ch.valid || sample_ch.ready) begin
				if (tx_idle_left > 0) begin
					tx_idle_left--;
					sample_ch.valid <= 1'b0;
				end else if (stim_q.size() == 0 || (stim_q[0].wait_drain &&
						(!outputs_drained || (sample_ch.valid && sample_ch.ready)))) begin
					sample_ch.valid <= 1'b0;
				end else begin
					next_item = stim_q.pop_front();
					sample_ch.valid     <= 1'b1;
					sample_ch.sample_in <= next_item.value;
					if (!tail_mode && tx_rate != 0 && $urandom_range(0, 15) < tx_rate) begin
						tx_idle_left = $urandom_range(1, 16);
					end
				end
			end
		end
	end

	// Stall the output once for a long stretch so the input backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: drive ready and compare each output transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			results_seen    <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen <= results_seen + 1;
				if (expected_filtered.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected filtered_sample %0d", result_ch.filtered_sample);
					end
				end else begin
					want = expected_filtered.pop_front();
					if (result_ch.filtered_sample !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("filtered_sample mismatch: expected %0d, got %0d",
								want, result_ch.filtered_sample);
						end
					end
				end
			end
			rx_cycle++;
			if (rx_cycle % 350 == 0) begin
				rx_rate = $urandom_range(0, 3);
			end
			if (tail_mode) begin
				rx_idle_left = 0;
			end
			if (rx_idle_left > 0) begin
				rx_idle_left--;
				result_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (!tail_mode && rx_rate != 0 && $urandom_range(0, 15) < rx_rate) begin
					rx_idle_left = $urandom_range(1, 16);
				end
			end
		end
	end

	// Wait for the stimulus to drain, then settle and report
	initial begin
		do @(negedge clk); while (stim_q.size() != 0 || sample_ch.valid);
		do @(negedge clk); while (expected_filtered.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_filtered.size() != 0) begin
			$display("%0d filtered samples never arrived", expected_filtered.size());
		end
		if (fail_count == 0 && expected_filtered.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#(LIMIT_NS);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/fdb_pkg.sv
hdl/fdb_ifs.sv
hdl/fdb_ram.sv
hdl/fdb_front.sv
hdl/fdb_queue.sv
hdl/fdb_mac.sv
hdl/fir_decimate_by_two.sv
test/tb_top.sv
